/* hw/rtl/slm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the stereo level meter.
// No dependencies; used by slm_if.sv and stereo_level_meter.sv.

package slm_pkg;

    localparam int unsigned MAX_WINDOW_DEF = 32768;

    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_DATA_W-1:0] CLIP_LEVEL_RST    = 16'd32000;
    localparam logic [CFG_DATA_W-1:0] WINDOW_FRAMES_RST = 16'd19200;

    localparam int SAMPLE_W = 16;
    localparam int ENERGY_W = 63;
    localparam int SUM_W    = 48;
    localparam int CLIP_W   = 33;
    localparam int WIN_W    = 47;
    localparam int INDEX_W  = 32;

    typedef enum logic [0:0] {
        CFG_CLIP_LEVEL    = 1'b0,
        CFG_WINDOW_FRAMES = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic                       last_frame;
    } t_frame;

    typedef struct packed {
        logic        [SAMPLE_W-1:0] peak_level;
        logic        [ENERGY_W-1:0] energy_total;
        logic signed [SUM_W-1:0]    left_sum;
        logic signed [SUM_W-1:0]    right_sum;
        logic        [CLIP_W-1:0]   clipped_count;
        logic        [SAMPLE_W-1:0] largest_jump;
        logic        [INDEX_W-1:0]  jump_frame;
        logic        [WIN_W-1:0]    loudest_window_energy;
        logic        [INDEX_W-1:0]  frame_total;
    } t_report;

endpackage

/* hw/rtl/slm_if.sv */
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the level meter frame input and report output.
// Depends on slm_pkg for the payload types.

interface slm_in_if;
    logic            valid;
    logic            ready;
    slm_pkg::t_frame payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface slm_out_if;
    logic             valid;
    logic             ready;
    slm_pkg::t_report payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/stereo_level_meter.sv */
`timescale 1ns / 1ps
// Stereo level meter: per-clip peak, energy, DC sums, clip count, largest jump
// and loudest sliding-window energy. Depends on slm_pkg and slm_if.

// The meter takes one stereo frame per clock while input ready is high, for any
// clip length; a frame goes through a four-stage pipeline (accept with delay-line
// read and write, squaring, accumulation, window-peak compare), and the report of
// a clip is loaded into the output register as its last frame leaves the final
// stage. The rate is set by the delay memory, which sees one write of the new
// frame and one read of the frame leaving the window per cycle, and by the
// window-energy update, which is combinational within the accumulation stage.
// Input ready drops only while one report waits in the output register and the
// next last frame has reached the final stage. There is no clearing pass after
// reset: the delay line is valid once written, so a window length changed in
// mid-clip may subtract frames of an earlier clip, or undefined data just after
// reset. Write configuration only while the meter is idle.

module stereo_level_meter #(
    parameter int unsigned MAX_WINDOW = slm_pkg::MAX_WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_index,
    input  logic [slm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    slm_in_if.sink                          i_in,
    slm_out_if.source                       o_out
);

    localparam int AW  = $clog2(MAX_WINDOW);
    localparam int WLW = $clog2(MAX_WINDOW + 1);
    localparam int SW  = slm_pkg::SAMPLE_W;
    localparam int IW  = slm_pkg::INDEX_W;
    localparam int EW  = slm_pkg::ENERGY_W;
    localparam int UW  = slm_pkg::SUM_W;
    localparam int CW  = slm_pkg::CLIP_W;
    localparam int WW  = slm_pkg::WIN_W;
    localparam logic [WLW-1:0] MAXW = WLW'(MAX_WINDOW);
    localparam logic [WLW-1:0] WIN_LEN_RST =
        (int'(slm_pkg::WINDOW_FRAMES_RST) > int'(MAX_WINDOW)) ?
        MAXW : WLW'(slm_pkg::WINDOW_FRAMES_RST);

    typedef struct packed {
        logic                 last;
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] r;
        logic [SW-1:0]        al;
        logic [SW-1:0]        ar;
        logic [SW-1:0]        jl;
        logic [SW-1:0]        jr;
        logic                 jflag;
        logic [IW-1:0]        idx;
        logic [IW-1:0]        ftot;
        logic                 sub;
        logic                 upd;
    } t_s1;

    typedef struct packed {
        logic                 last;
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] r;
        logic [31:0]          fe;
        logic [31:0]          oe;
        logic [SW-1:0]        pk;
        logic [1:0]           clipn;
        logic [SW-1:0]        jc;
        logic                 jflag;
        logic [IW-1:0]        idx;
        logic [IW-1:0]        ftot;
        logic                 sub;
        logic                 upd;
    } t_s2;

    typedef struct packed {
        logic                 last;
        logic                 upd;
        logic [WW-1:0]        win;
        logic [SW-1:0]        peak;
        logic [EW-1:0]        energy;
        logic signed [UW-1:0] lsum;
        logic signed [UW-1:0] rsum;
        logic [CW-1:0]        clip;
        logic [SW-1:0]        jump;
        logic [IW-1:0]        jpos;
        logic [IW-1:0]        ftot;
    } t_s3;

    function automatic logic [SW-1:0] abs_diff(input logic signed [SW-1:0] a,
                                               input logic signed [SW-1:0] b);
        logic signed [SW:0] d;
        d = (SW+1)'(a) - (SW+1)'(b);
        return d[SW] ? SW'(-d) : SW'(d);
    endfunction

    function automatic logic [31:0] square(input logic signed [SW-1:0] v);
        logic signed [31:0] p;
        p = 32'(v) * 32'(v);
        return p;
    endfunction

    // configuration
    logic [SW-1:0]  r_clip_level;
    logic [WLW-1:0] r_win_len;
    logic [WLW-1:0] n_win_len;

    // clip state
    logic [IW-1:0]        r_frame_index;
    logic signed [SW-1:0] r_prev_l;
    logic signed [SW-1:0] r_prev_r;
    logic [SW-1:0]        r_peak;
    logic [EW-1:0]        r_energy;
    logic signed [UW-1:0] r_lsum;
    logic signed [UW-1:0] r_rsum;
    logic [CW-1:0]        r_clip;
    logic [SW-1:0]        r_jump;
    logic [IW-1:0]        r_jpos;
    logic [WW-1:0]        r_win;
    logic [WW-1:0]        r_best;

    // delay line
    logic [2*SW-1:0] r_delay [MAX_WINDOW];
    logic [2*SW-1:0] r_rd_q;
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   rd_addr;
    logic [WLW-1:0]  ptr_ext;

    // pipeline
    logic             r_s1_valid, r_s2_valid, r_s3_valid;
    t_s1              r_s1, n_s1;
    t_s2              r_s2, n_s2;
    t_s3              r_s3, n_s3;
    logic             r_out_valid;
    slm_pkg::t_report r_out;

    logic             adv;
    logic             in_acc;
    slm_pkg::t_frame  in_frame;
    logic [IW-1:0]    frame_inc;

    logic signed [SW-1:0] old_l, old_r;
    logic [63:0]          e_sum;
    logic signed [UW:0]   l_sum, r_sum;
    logic [CW:0]          c_sum;
    logic [WW:0]          w_sum;
    logic [WW-1:0]        w_sat, w_old;
    logic [WW-1:0]        u_best;

    assign in_frame = i_in.payload;
    // stall only when a second report reaches the last stage while one is held
    assign adv      = !(r_s3_valid && r_s3.last && r_out_valid && !o_out.ready);
    assign in_acc   = i_in.valid && adv;
    assign i_in.ready = adv;

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_win_len = WLW'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_WINDOW)) begin
            n_win_len = MAXW;
        end else begin
            n_win_len = WLW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_level <= slm_pkg::CLIP_LEVEL_RST;
            r_win_len    <= WIN_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (slm_pkg::t_cfg_reg'(i_cfg_index))
                slm_pkg::CFG_CLIP_LEVEL:    r_clip_level <= i_cfg_data;
                slm_pkg::CFG_WINDOW_FRAMES: r_win_len    <= n_win_len;
            endcase
        end
    end

    // ---------------- stage 0: accept, delay line access ----------------
    assign frame_inc = (r_frame_index == '1) ? r_frame_index : r_frame_index + IW'(1);
    assign ptr_ext   = WLW'(r_wr_ptr);

    always_comb begin
        if (ptr_ext >= r_win_len) begin
            rd_addr = AW'(ptr_ext - r_win_len);
        end else begin
            rd_addr = AW'(ptr_ext + MAXW - r_win_len);
        end
    end

    always_comb begin
        n_s1.last  = in_frame.last_frame;
        n_s1.l     = in_frame.left_sample;
        n_s1.r     = in_frame.right_sample;
        n_s1.al    = abs_diff(in_frame.left_sample, '0);
        n_s1.ar    = abs_diff(in_frame.right_sample, '0);
        n_s1.jl    = abs_diff(in_frame.left_sample, r_prev_l);
        n_s1.jr    = abs_diff(in_frame.right_sample, r_prev_r);
        n_s1.jflag = (r_frame_index != '0);
        n_s1.idx   = r_frame_index;
        n_s1.ftot  = frame_inc;
        n_s1.sub   = (r_frame_index >= IW'(r_win_len));
        n_s1.upd   = (r_frame_index >= IW'(r_win_len) - IW'(1));
    end

    // read-first: with a full-length window the entry leaving is the one overwritten
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_delay[r_wr_ptr] <= {in_frame.right_sample, in_frame.left_sample};
            r_rd_q            <= r_delay[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr      <= '0;
            r_frame_index <= '0;
            r_prev_l      <= '0;
            r_prev_r      <= '0;
        end else if (in_acc) begin
            r_wr_ptr      <= (r_wr_ptr == AW'(MAX_WINDOW - 1)) ? '0 : r_wr_ptr + AW'(1);
            r_frame_index <= in_frame.last_frame ? '0 : frame_inc;
            r_prev_l      <= in_frame.left_sample;
            r_prev_r      <= in_frame.right_sample;
        end
    end

    // ---------------- stage 1: squares and per-frame reductions ----------------
    assign old_l = $signed(r_rd_q[SW-1:0]);
    assign old_r = $signed(r_rd_q[2*SW-1:SW]);

    always_comb begin
        n_s2.last  = r_s1.last;
        n_s2.l     = r_s1.l;
        n_s2.r     = r_s1.r;
        n_s2.fe    = square(r_s1.l) + square(r_s1.r);
        n_s2.oe    = square(old_l) + square(old_r);
        n_s2.pk    = (r_s1.ar > r_s1.al) ? r_s1.ar : r_s1.al;
        n_s2.clipn = 2'(r_s1.al >= r_clip_level) + 2'(r_s1.ar >= r_clip_level);
        // ties keep left, which is checked first
        n_s2.jc    = (r_s1.jr > r_s1.jl) ? r_s1.jr : r_s1.jl;
        n_s2.jflag = r_s1.jflag;
        n_s2.idx   = r_s1.idx;
        n_s2.ftot  = r_s1.ftot;
        n_s2.sub   = r_s1.sub;
        n_s2.upd   = r_s1.upd;
    end

    // ---------------- stage 2: accumulate ----------------
    assign e_sum = {1'b0, r_energy} + 64'(r_s2.fe);
    assign l_sum = (UW+1)'(r_lsum) + (UW+1)'($signed(r_s2.l));
    assign r_sum = (UW+1)'(r_rsum) + (UW+1)'($signed(r_s2.r));
    assign c_sum = {1'b0, r_clip} + (CW+1)'(r_s2.clipn);
    assign w_sum = {1'b0, r_win} + (WW+1)'(r_s2.fe);
    assign w_sat = w_sum[WW] ? '1 : w_sum[WW-1:0];
    assign w_old = r_s2.sub ? WW'(r_s2.oe) : '0;

    always_comb begin
        n_s3.last   = r_s2.last;
        n_s3.upd    = r_s2.upd;
        n_s3.ftot   = r_s2.ftot;
        n_s3.energy = e_sum[EW] ? '1 : e_sum[EW-1:0];
        n_s3.lsum   = (l_sum[UW] != l_sum[UW-1]) ? {l_sum[UW], {(UW-1){~l_sum[UW]}}}
                                                  : l_sum[UW-1:0];
        n_s3.rsum   = (r_sum[UW] != r_sum[UW-1]) ? {r_sum[UW], {(UW-1){~r_sum[UW]}}}
                                                  : r_sum[UW-1:0];
        n_s3.clip   = c_sum[CW] ? '1 : c_sum[CW-1:0];
        n_s3.peak   = (r_s2.pk > r_peak) ? r_s2.pk : r_peak;
        if (r_s2.jflag && r_s2.jc > r_jump) begin
            n_s3.jump = r_s2.jc;
            n_s3.jpos = r_s2.idx;
        end else begin
            n_s3.jump = r_jump;
            n_s3.jpos = r_jpos;
        end
        // floor at zero once the leaving frame is taken out
        n_s3.win    = (w_sat > w_old) ? w_sat - w_old : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak   <= '0;
            r_energy <= '0;
            r_lsum   <= '0;
            r_rsum   <= '0;
            r_clip   <= '0;
            r_jump   <= '0;
            r_jpos   <= '0;
            r_win    <= '0;
        end else if (r_s2_valid && adv) begin
            if (r_s2.last) begin
                r_peak   <= '0;
                r_energy <= '0;
                r_lsum   <= '0;
                r_rsum   <= '0;
                r_clip   <= '0;
                r_jump   <= '0;
                r_jpos   <= '0;
                r_win    <= '0;
            end else begin
                r_peak   <= n_s3.peak;
                r_energy <= n_s3.energy;
                r_lsum   <= n_s3.lsum;
                r_rsum   <= n_s3.rsum;
                r_clip   <= n_s3.clip;
                r_jump   <= n_s3.jump;
                r_jpos   <= n_s3.jpos;
                r_win    <= n_s3.win;
            end
        end
    end

    // ---------------- stage 3: loudest window, report ----------------
    assign u_best = (r_s3.upd && r_s3.win > r_best) ? r_s3.win : r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else if (r_s3_valid && adv) begin
            r_best <= r_s3.last ? '0 : u_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s3_valid && r_s3.last && adv) begin
            r_out.peak_level            <= r_s3.peak;
            r_out.energy_total          <= r_s3.energy;
            r_out.left_sum              <= r_s3.lsum;
            r_out.right_sum             <= r_s3.rsum;
            r_out.clipped_count         <= r_s3.clip;
            r_out.largest_jump          <= r_s3.jump;
            r_out.jump_frame            <= r_s3.jpos;
            r_out.loudest_window_energy <= u_best;
            r_out.frame_total           <= r_s3.ftot;
        end
    end

    // ---------------- pipeline control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_valid <= in_acc;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
            end
            if (r_s3_valid && r_s3.last && adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    // ---------------- assertions ----------------
    a_hold_on_second_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && r_s3.last && o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while a report is blocked at the last stage");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2.last && adv) |=>
        (r_energy == '0 && r_peak == '0 && r_win == '0 && r_clip == '0))
        else $error("statistics not cleared after the last frame");

    a_index_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_frame.last_frame) |=> (r_frame_index == '0))
        else $error("frame index not restarted after the last frame");

    a_read_write_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (rd_addr != r_wr_ptr || r_win_len == MAXW))
        else $error("delay line read collides with the write of the same frame");

endmodule

/* dv/tb_stereo_level_meter.sv */
`timescale 1ns / 1ps
// Self-checking testbench for stereo_level_meter: directed frames, random clips and one
// long clip over a wide window, every report compared against a cycle-free predictor
// or a hand-worked report. Depends on slm_pkg, slm_if.sv and stereo_level_meter.sv.

module tb_stereo_level_meter;

    localparam int MAX_WINDOW     = slm_pkg::MAX_WINDOW_DEF;
    localparam int RANDOM_FRAMES  = 1130;
    localparam int LONG_CLIP      = 560;
    localparam logic [15:0] LONG_WINDOW = 16'd400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 300;
    localparam int END_WAIT       = 2000;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    localparam longint SUM_HI = 64'sd140737488355327;
    localparam longint SUM_LO = -64'sd140737488355328;
    localparam longint unsigned ENERGY_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned WIN_CAP    = 64'h0000_7FFF_FFFF_FFFF;

    typedef struct {
        bit               set_cfg;
        logic [15:0]      clip;
        logic [15:0]      window;
        slm_pkg::t_frame  frame;
        bit               pinned;
        slm_pkg::t_report want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [slm_pkg::CFG_DATA_W-1:0] cfg_data;

    slm_in_if  frame_if ();
    slm_out_if report_if ();

    stereo_level_meter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (frame_if),
        .o_out       (report_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Meter state as the block should hold it.
    logic [15:0]        clip_thresh;
    logic [15:0]        window_len;
    logic [15:0]        peak_lvl;
    logic [62:0]        energy_sum;
    logic signed [47:0] left_total;
    logic signed [47:0] right_total;
    logic [32:0]        clip_cnt;
    logic [15:0]        max_jump;
    logic [31:0]        max_jump_at;
    logic [46:0]        win_energy;
    logic [46:0]        best_win;
    logic [31:0]        frame_idx;
    logic [31:0]        prev_frame;
    logic [31:0]        delay_line [MAX_WINDOW];
    int unsigned        wr_pos;

    slm_pkg::t_report pending_reports [$];
    t_row             script [$];

    int src_max_gap = 5;
    int sink_max_gap = 5;
    int holds_asked = 0;
    int holds_done = 0;
    int mismatches = 0;
    int frames_sent = 0;
    int clips_closed = 0;
    int reports_checked = 0;
    int settings_used = 0;

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("report %0d %s: got 0x%0h, expected 0x%0h",
                                    reports_checked, name, got, want));
    endtask

    function automatic void clear_clip_stats();
        peak_lvl    = '0;
        energy_sum  = '0;
        left_total  = '0;
        right_total = '0;
        clip_cnt    = '0;
        max_jump    = '0;
        max_jump_at = '0;
        win_energy  = '0;
        best_win    = '0;
        frame_idx   = '0;
        prev_frame  = '0;
    endfunction

    function automatic logic signed [47:0] sum_sat(input logic signed [47:0] acc, input int v);
        longint total;
        total = longint'(acc) + v;
        if (total > SUM_HI) total = SUM_HI;
        else if (total < SUM_LO) total = SUM_LO;
        return total[47:0];
    endfunction

    // Fold one accepted frame into the statistics; close the clip on its last frame.
    function automatic void meter_take_frame(input slm_pkg::t_frame f, output bit has_report,
                                             output slm_pkg::t_report r);
        int s [2];
        int p [2];
        int ch;
        int d;
        int unsigned mag;
        int unsigned jump_mag;
        int unsigned w;
        longint unsigned sq;
        longint unsigned old_nrg;
        longint lo;
        longint hi;
        logic [31:0] old;

        s[0] = f.left_sample;
        s[1] = f.right_sample;
        p[0] = $signed(prev_frame[15:0]);
        p[1] = $signed(prev_frame[31:16]);
        for (ch = 0; ch < 2; ch++) begin
            mag = (s[ch] < 0) ? -s[ch] : s[ch];
            sq  = longint'(mag) * longint'(mag);
            if (64'(energy_sum) + sq > ENERGY_CAP) energy_sum = '1;
            else energy_sum = energy_sum + sq[62:0];
            if (mag > peak_lvl) peak_lvl = mag[15:0];
            if (mag >= clip_thresh && clip_cnt != '1) clip_cnt++;
            // no jump on the first frame of a clip; left wins a tie within a frame
            if (frame_idx != 0) begin
                d = s[ch] - p[ch];
                jump_mag = (d < 0) ? -d : d;
                if (jump_mag > max_jump) begin
                    max_jump    = jump_mag[15:0];
                    max_jump_at = frame_idx;
                end
            end
            if (64'(win_energy) + sq > WIN_CAP) win_energy = '1;
            else win_energy = win_energy + sq[46:0];
        end
        left_total  = sum_sat(left_total, s[0]);
        right_total = sum_sat(right_total, s[1]);

        w = window_len;
        if (w == 0) w = 1;
        if (w > MAX_WINDOW) w = MAX_WINDOW;
        if (frame_idx >= w) begin
            old = delay_line[(wr_pos + MAX_WINDOW - w) % MAX_WINDOW];
            lo = $signed(old[15:0]);
            hi = $signed(old[31:16]);
            old_nrg = lo * lo + hi * hi;
            win_energy = (win_energy > old_nrg) ? win_energy - old_nrg[46:0] : '0;
        end
        delay_line[wr_pos] = {f.right_sample, f.left_sample};
        wr_pos = (wr_pos + 1) % MAX_WINDOW;
        if (frame_idx >= w - 1 && win_energy > best_win) best_win = win_energy;

        prev_frame = {f.right_sample, f.left_sample};
        if (frame_idx != '1) frame_idx++;

        has_report = f.last_frame;
        r = '0;
        if (has_report) begin
            r.peak_level            = peak_lvl;
            r.energy_total          = energy_sum;
            r.left_sum              = left_total;
            r.right_sum             = right_total;
            r.clipped_count         = clip_cnt;
            r.largest_jump          = max_jump;
            r.jump_frame            = max_jump_at;
            r.loudest_window_energy = best_win;
            r.frame_total           = frame_idx;
            clear_clip_stats();
        end
    endfunction

    function automatic logic signed [15:0] rand_sample();
        int v;
        case ($urandom_range(0, 9))
            0: v = -32768;
            1: v = 32767;
            2: begin
                // straddle the clip threshold
                v = int'(clip_thresh) + int'($urandom_range(0, 2)) - 1;
                if (v < 0) v = 0;
                if (v > 32768) v = 32768;
                if (v == 32768 || $urandom_range(0, 1) == 1) v = -v;
            end
            3, 4: v = int'($urandom_range(0, 400)) - 200;
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return v[15:0];
    endfunction

    task automatic add_row(input bit set_cfg, input logic [15:0] clip,
                           input logic [15:0] window, input int left, input int right,
                           input bit is_last);
        t_row row;
        row.set_cfg            = set_cfg;
        row.clip               = clip;
        row.window             = window;
        row.frame.left_sample  = left[15:0];
        row.frame.right_sample = right[15:0];
        row.frame.last_frame   = is_last;
        row.pinned             = 1'b0;
        row.want               = '0;
        script.push_back(row);
    endtask

    // Attach a hand-worked report to the row just added.
    task automatic pin_report(input logic [15:0] peak, input logic [62:0] energy,
                              input logic signed [47:0] lsum, input logic signed [47:0] rsum,
                              input logic [32:0] clips, input logic [15:0] jump,
                              input logic [31:0] jump_at, input logic [46:0] best,
                              input logic [31:0] frames);
        t_row row;
        row = script.pop_back();
        row.pinned                     = 1'b1;
        row.want.peak_level            = peak;
        row.want.energy_total          = energy;
        row.want.left_sum              = lsum;
        row.want.right_sum             = rsum;
        row.want.clipped_count         = clips;
        row.want.largest_jump          = jump;
        row.want.jump_frame            = jump_at;
        row.want.loudest_window_energy = best;
        row.want.frame_total           = frames;
        script.push_back(row);
    endtask

    task automatic send_frame(input slm_pkg::t_frame f, input bit use_pinned,
                              input slm_pkg::t_report pinned);
        int gap;
        bit has_report;
        slm_pkg::t_report predicted;
        gap = $urandom_range(0, src_max_gap);
        if (gap != 0) begin
            frame_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        frame_if.valid   <= 1'b1;
        frame_if.payload <= f;
        do @(posedge i_clk); while (frame_if.ready !== 1'b1);
        meter_take_frame(f, has_report, predicted);
        if (has_report) begin
            pending_reports.push_back(use_pinned ? pinned : predicted);
            clips_closed++;
        end
        frames_sent++;
    endtask

    // Hold off until every report is back and the pipeline has drained.
    task automatic settle();
        frame_if.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] clip, input logic [15:0] window);
        cfg_we    <= 1'b1;
        cfg_index <= slm_pkg::CFG_CLIP_LEVEL;
        cfg_data  <= clip;
        @(posedge i_clk);
        cfg_index <= slm_pkg::CFG_WINDOW_FRAMES;
        cfg_data  <= window;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        clip_thresh = clip;
        window_len  = window;
        settings_used++;
    endtask

    initial begin : report_sink
        int gap;
        slm_pkg::t_report want;
        slm_pkg::t_report got;
        report_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = $urandom_range(0, sink_max_gap);
            if (holds_done != holds_asked) begin
                gap = LONG_HOLD;
                holds_done++;
            end
            if (gap != 0) begin
                report_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            report_if.ready <= 1'b1;
            do @(posedge i_clk); while (report_if.valid !== 1'b1);
            got = report_if.payload;
            if (pending_reports.size() == 0) begin
                flag_mismatch("report arrived with no clip end pending");
            end else begin
                want = pending_reports.pop_front();
                reports_checked++;
                check_field("peak_level", got.peak_level, want.peak_level);
                check_field("energy_total", got.energy_total, want.energy_total);
                check_field("left_sum", got.left_sum, want.left_sum);
                check_field("right_sum", got.right_sum, want.right_sum);
                check_field("clipped_count", got.clipped_count, want.clipped_count);
                check_field("largest_jump", got.largest_jump, want.largest_jump);
                check_field("jump_frame", got.jump_frame, want.jump_frame);
                check_field("loudest_window_energy", got.loudest_window_energy,
                            want.loudest_window_energy);
                check_field("frame_total", got.frame_total, want.frame_total);
            end
        end
    end

    initial begin : stimulus
        slm_pkg::t_frame f;
        int k;
        int c;
        int n_clips;
        int len;
        int phase;
        int random_frames;
        int wait_cycles;
        int unsigned eff;
        logic [15:0] clip;
        logic [15:0] win;

        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = slm_pkg::CFG_CLIP_LEVEL;
        cfg_data         = '0;
        frame_if.valid   = 1'b0;
        frame_if.payload = '0;
        clear_clip_stats();
        for (k = 0; k < MAX_WINDOW; k++) delay_line[k] = '0;
        wr_pos      = 0;
        clip_thresh = slm_pkg::CLIP_LEVEL_RST;
        window_len  = slm_pkg::WINDOW_FRAMES_RST;

        // One-frame clips at reset settings: full-scale extremes, then silence.
        add_row(0, 0, 0, -32768, 32767, 1);
        pin_report(16'd32768, 63'd2147418113, -48'sd32768, 48'sd32767, 33'd2, 0, 0, 0, 1);
        add_row(0, 0, 0, 0, 0, 1);
        pin_report(0, 0, 0, 0, 0, 0, 0, 0, 1);
        // Full-swing jump on both channels at once: left is kept.
        add_row(0, 0, 0, 32767, -32768, 0);
        add_row(0, 0, 0, -32768, 32767, 0);
        add_row(0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 100, -100, 1);
        pin_report(16'd32768, 63'd4294856226, 48'sd99, -48'sd101, 33'd4, 16'd65535, 1, 0, 4);
        // Clip level zero counts silence as clipped.
        add_row(1, 16'd0, 16'd19200, 0, 0, 1);
        pin_report(0, 0, 0, 0, 33'd2, 0, 0, 0, 1);
        // Window length zero behaves as one frame.
        add_row(1, 16'd32000, 16'd0, 3, 4, 0);
        add_row(0, 0, 0, -5, 12, 0);
        add_row(0, 0, 0, 1, 1, 1);
        add_row(1, 16'd32768, 16'd1, -32768, 32767, 0);
        add_row(0, 0, 0, -32767, -32768, 1);
        // Window above the delay depth, clip level above full scale.
        add_row(1, 16'd65535, 16'd65535, -32768, -32768, 1);
        pin_report(16'd32768, 63'd2147483648, -48'sd32768, -48'sd32768, 0, 0, 0, 0, 1);
        // Equal jumps across frames: the earlier one is kept.
        add_row(1, 16'd16, 16'd2, 0, 0, 0);
        add_row(0, 0, 0, 10, 0, 0);
        add_row(0, 0, 0, 20, -10, 1);
        add_row(1, 16'd1000, 16'd32768, 1000, -1000, 0);
        add_row(0, 0, 0, -999, 999, 0);
        add_row(0, 0, 0, 0, 32767, 0);
        add_row(0, 0, 0, 5, 5, 1);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[n]) begin
            if (script[n].set_cfg) begin
                settle();
                configure(script[n].clip, script[n].window);
            end
            send_frame(script[n].frame, script[n].pinned, script[n].want);
        end

        phase = 0;
        random_frames = 0;
        while (random_frames < RANDOM_FRAMES || phase <= 3) begin
            settle();
            case ($urandom_range(0, 5))
                0: clip = 16'd0;
                1: clip = 16'd32768;
                2: clip = 16'd65535;
                3: clip = 16'd32767;
                default: clip = 16'($urandom_range(16000, 33000));
            endcase
            case ($urandom_range(0, 7))
                0: win = 16'd0;
                1: win = 16'd1;
                2: win = 16'($urandom_range(2, 8));
                3, 4: win = 16'($urandom_range(2, 64));
                5: win = 16'd32768;
                6: win = 16'd65535;
                default: win = 16'($urandom_range(0, 65535));
            endcase
            configure(clip, win);
            eff = (win == 0) ? 1 : ((win > MAX_WINDOW) ? MAX_WINDOW : win);
            case ($urandom_range(0, 3))
                0: begin src_max_gap = 0; sink_max_gap = 0; end
                1: begin src_max_gap = 5; sink_max_gap = 0; end
                2: begin src_max_gap = 0; sink_max_gap = 5; end
                default: begin src_max_gap = 5; sink_max_gap = 5; end
            endcase
            n_clips = $urandom_range(1, 6);
            if (phase == 3) begin
                // stall the output for a long stretch while one-frame clips keep coming
                holds_asked++;
                src_max_gap  = 0;
                sink_max_gap = 0;
                n_clips      = 40;
            end
            for (c = 0; c < n_clips; c++) begin
                if (phase == 3 || $urandom_range(0, 6) == 0) len = 1;
                else if (eff <= 64) len = $urandom_range(1, 2 * eff + 8);
                else len = $urandom_range(1, 48);
                for (k = 0; k < len; k++) begin
                    f.left_sample  = rand_sample();
                    f.right_sample = rand_sample();
                    f.last_frame   = (k == len - 1);
                    send_frame(f, 1'b0, '0);
                    random_frames++;
                end
            end
            phase++;
        end

        // One long clip that fills a wide window and then slides it on.
        settle();
        configure(16'($urandom_range(0, 65535)), LONG_WINDOW);
        src_max_gap  = 0;
        sink_max_gap = 5;
        for (k = 0; k < LONG_CLIP; k++) begin
            f.left_sample  = rand_sample();
            f.right_sample = rand_sample();
            f.last_frame   = (k == LONG_CLIP - 1);
            send_frame(f, 1'b0, '0);
        end

        frame_if.valid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < END_WAIT && pending_reports.size() != 0;
             wait_cycles++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_reports.size() != 0)
            flag_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));

        $display("Sent %0d frames in %0d clips over %0d register settings, last clip %0d long.",
                 frames_sent, clips_closed, settings_used, LONG_CLIP);
        $display("Compared %0d reports, %0d mismatches.", reports_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("Timed out after %0d cycles.", TIMEOUT_CYCLES);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
